// ===== src/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and constants of the interval list difference block.
// ----------------------------------------------------------------------------
package ild_pkg;

  localparam int TICK_W      = 48;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;

  typedef logic signed [TICK_W-1:0] tick_t;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_RUN      = 2'd2
  } op_t;

  // Function codes as they arrive on the input channel.
  localparam logic [1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [1:0] FUNC_RUN      = 2'd2;

  typedef struct packed {
    op_t   op;
    tick_t rise_time;
    tick_t set_time;
  } cmd_t;

  typedef struct packed {
    tick_t rise_time;
    tick_t set_time;
  } interval_t;

endpackage

// ===== src/interval_list_difference.sv =====
// ----------------------------------------------------------------------------
// interval_list_difference
// Loads two sorted interval lists, A and B, and computes A minus B.
// ----------------------------------------------------------------------------
// Input transactions carry func, rise_time and set_time: func 0 appends an
// interval to list A, func 1 to list B, func 2 runs the difference and the
// unused code is accepted and ignored. Each list holds MAX_INTERVALS entries;
// an append to a full list is dropped and reported as overflow_seen on every
// result of the next run. A run emits one output transaction per surviving
// piece of A (at most 32), the final one with last_interval set, or a single
// transaction with interval_valid low when the result is empty.
// A command passes an input register and a two-entry command queue before
// the list engine, and input transactions keep flowing while the engine works.
// An append is done in the idle state. A run starts there, then makes per
// merge step a RAM read (S_FETCH) and a compare step (S_STEP), at most
// count_a + count_b steps, and closes with a last read, the end check and
// the final result (S_FINISH); the first result leaves once a second piece is
// found or the walk ends.
// A stalled output holds the walk at the next step that produces a piece,
// and the queue then fills and stalls the input.
// Reset empties both lists and the queue and clears the overflow flag.
// ----------------------------------------------------------------------------
module interval_list_difference #(
  parameter int MAX_INTERVALS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     func,
  input  ild_pkg::tick_t rise_time,
  input  ild_pkg::tick_t set_time,
  output logic           out_valid,
  input  logic           out_stall,
  output ild_pkg::tick_t out_rise,
  output ild_pkg::tick_t out_set,
  output logic           interval_valid,
  output logic           last_interval,
  output logic           overflow_seen
);

  logic          push_valid;
  logic          push_ready;
  ild_pkg::cmd_t push_cmd;
  logic          q_valid;
  logic          q_pop;
  ild_pkg::cmd_t q_cmd;

  ild_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .rise_time  (rise_time),
    .set_time   (set_time),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ild_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  ild_engine #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_pop        (q_pop),
    .cmd            (q_cmd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rise       (out_rise),
    .out_set        (out_set),
    .interval_valid (interval_valid),
    .last_interval  (last_interval),
    .overflow_seen  (overflow_seen)
  );

endmodule

// ===== src/ild_ram.sv =====
// ----------------------------------------------------------------------------
// ild_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ild_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ild_front.sv =====
// ----------------------------------------------------------------------------
// ild_front
// Input stage: accepts transactions, decodes the function code into a
// command and hands it to the command queue. Unused codes are dropped here.
// ----------------------------------------------------------------------------
module ild_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  ild_pkg::tick_t      rise_time,
  input  ild_pkg::tick_t      set_time,
  output logic                push_valid,
  input  logic                push_ready,
  output ild_pkg::cmd_t       push_cmd
);

  logic          cmd_valid;
  ild_pkg::cmd_t cmd;
  logic          dec_ok;
  ild_pkg::op_t  dec_op;

  always_comb begin
    dec_ok = 1'b1;
    dec_op = ild_pkg::OP_RUN;
    case (func)
      ild_pkg::FUNC_APPEND_A: dec_op = ild_pkg::OP_APPEND_A;
      ild_pkg::FUNC_APPEND_B: dec_op = ild_pkg::OP_APPEND_B;
      ild_pkg::FUNC_RUN:      dec_op = ild_pkg::OP_RUN;
      default:                dec_ok = 1'b0;
    endcase
  end

  assign in_stall   = cmd_valid && !push_ready;
  assign push_valid = cmd_valid;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      cmd_valid <= dec_ok;
    end else if (push_ready) begin
      cmd_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      cmd.op        <= dec_op;
      cmd.rise_time <= rise_time;
      cmd.set_time  <= set_time;
    end
  end

endmodule

// ===== src/ild_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ild_cmd_queue
// Two-entry command queue between the front stage and the list engine.
// ----------------------------------------------------------------------------
module ild_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ild_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output ild_pkg::cmd_t pop_cmd
);

  ild_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/ild_engine.sv =====
// ----------------------------------------------------------------------------
// ild_engine
// List engine: executes appends into the two list RAMs and runs the merge
// walk that produces A minus B, one merge step per fetch/step pair.
// ----------------------------------------------------------------------------
module ild_engine #(
  parameter int MAX_INTERVALS = 16,
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
  localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  ild_pkg::cmd_t  cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output ild_pkg::tick_t out_rise,
  output ild_pkg::tick_t out_set,
  output logic           interval_valid,
  output logic           last_interval,
  output logic           overflow_seen
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_STEP,
    S_FINISH
  } state_t;

  localparam logic [CW-1:0] LIST_FULL = CW'(MAX_INTERVALS);

  state_t              state;
  logic [CW-1:0]       count_a;
  logic [CW-1:0]       count_b;
  logic [CW-1:0]       ia;
  logic [CW-1:0]       ib;
  logic [CW-1:0]       ia_next;
  logic [CW-1:0]       ib_next;
  logic                load_a;
  logic                load_b;
  logic                dropped_flag;
  ild_pkg::tick_t      work_a_rise;
  ild_pkg::tick_t      work_b_rise;
  ild_pkg::tick_t      a_set;
  ild_pkg::tick_t      b_set;
  logic                pend_valid;
  ild_pkg::tick_t      pend_rise;
  ild_pkg::tick_t      pend_set;
  logic [ild_pkg::RES_W-1:0] n_pieces;

  ild_pkg::interval_t  a_rd;
  ild_pkg::interval_t  b_rd;
  ild_pkg::interval_t  wr_data;
  logic                we_a;
  logic                we_b;

  logic                a_done;
  logic                b_done;
  logic                out_free;
  logic                emit;
  logic                keep;
  logic                adv_a;
  logic                adv_b;
  logic                step_go;
  ild_pkg::tick_t      em_rise;
  ild_pkg::tick_t      em_set;
  ild_pkg::tick_t      ar_new;
  ild_pkg::tick_t      br_new;

  assign a_done   = (ia >= count_a);
  assign b_done   = (ib >= count_b);
  assign out_free = !out_valid || !out_stall;
  assign keep     = (n_pieces < ild_pkg::RES_W'(ild_pkg::MAX_RESULTS));
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  assign wr_data.rise_time = cmd.rise_time;
  assign wr_data.set_time  = cmd.set_time;
  assign we_a = cmd_pop && (cmd.op == ild_pkg::OP_APPEND_A) && (count_a < LIST_FULL);
  assign we_b = cmd_pop && (cmd.op == ild_pkg::OP_APPEND_B) && (count_b < LIST_FULL);

  // The four overlap cases of one merge step, plus the pass-through once B
  // is used up.
  always_comb begin
    emit    = 1'b0;
    em_rise = work_a_rise;
    em_set  = a_set;
    adv_a   = 1'b0;
    adv_b   = 1'b0;
    ar_new  = work_a_rise;
    br_new  = work_b_rise;
    if (b_done) begin
      emit  = 1'b1;
      adv_a = 1'b1;
    end else if (work_a_rise >= work_b_rise && a_set <= b_set) begin
      br_new = a_set;
      adv_a  = 1'b1;
    end else if (work_a_rise < work_b_rise && a_set > b_set) begin
      emit   = 1'b1;
      em_set = work_b_rise;
      ar_new = b_set;
      adv_b  = 1'b1;
    end else if (work_a_rise < work_b_rise) begin
      emit  = 1'b1;
      adv_a = 1'b1;
      if (!(work_b_rise > a_set)) begin
        em_set = work_b_rise;
        br_new = a_set;
      end
    end else begin
      adv_b = 1'b1;
      if (!(work_a_rise > b_set)) begin
        ar_new = b_set;
      end
    end
  end

  assign step_go = (state == S_STEP) && !a_done && (!emit || out_free);

  // Read addresses follow the next index so that data is ready in S_FETCH.
  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (cmd_pop && cmd.op == ild_pkg::OP_RUN) begin
      ia_next = '0;
      ib_next = '0;
    end else if (step_go) begin
      ia_next = ia + CW'(adv_a);
      ib_next = ib + CW'(adv_b);
    end
  end

  ild_ram #(
    .WIDTH ($bits(ild_pkg::interval_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (wr_data),
    .raddr (ia_next[AW-1:0]),
    .rdata (a_rd)
  );

  ild_ram #(
    .WIDTH ($bits(ild_pkg::interval_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (wr_data),
    .raddr (ib_next[AW-1:0]),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      ia           <= '0;
      ib           <= '0;
      load_a       <= 1'b0;
      load_b       <= 1'b0;
      dropped_flag <= 1'b0;
      pend_valid   <= 1'b0;
      n_pieces     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              ild_pkg::OP_APPEND_A: begin
                if (we_a) begin
                  count_a <= count_a + CW'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              ild_pkg::OP_APPEND_B: begin
                if (we_b) begin
                  count_b <= count_b + CW'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              ild_pkg::OP_RUN: begin
                ia         <= ia_next;
                ib         <= ib_next;
                load_a     <= 1'b1;
                load_b     <= 1'b1;
                n_pieces   <= '0;
                pend_valid <= 1'b0;
                state      <= S_FETCH;
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          if (load_a && !a_done) begin
            work_a_rise <= a_rd.rise_time;
            a_set       <= a_rd.set_time;
          end
          if (load_b && !b_done) begin
            work_b_rise <= b_rd.rise_time;
            b_set       <= b_rd.set_time;
          end
          load_a <= 1'b0;
          load_b <= 1'b0;
          state  <= S_STEP;
        end
        S_STEP: begin
          if (a_done) begin
            state <= S_FINISH;
          end else if (step_go) begin
            work_a_rise <= ar_new;
            work_b_rise <= br_new;
            ia          <= ia_next;
            ib          <= ib_next;
            load_a      <= adv_a;
            load_b      <= adv_b;
            state       <= S_FETCH;
            // A piece is held back one place so the final one can be marked.
            if (emit && keep) begin
              if (pend_valid) begin
                out_valid      <= 1'b1;
                out_rise       <= pend_rise;
                out_set        <= pend_set;
                interval_valid <= 1'b1;
                last_interval  <= 1'b0;
                overflow_seen  <= dropped_flag;
              end
              pend_valid <= 1'b1;
              pend_rise  <= em_rise;
              pend_set   <= em_set;
              n_pieces   <= n_pieces + ild_pkg::RES_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_rise       <= pend_valid ? pend_rise : '0;
            out_set        <= pend_valid ? pend_set : '0;
            interval_valid <= pend_valid;
            last_interval  <= 1'b1;
            overflow_seen  <= dropped_flag;
            dropped_flag   <= 1'b0;
            pend_valid     <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
